// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset
`define PPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define PPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ppmfsd_pkg.sv -----
// Types, codes and reset values for the PPM frame sync and channel decoder
package ppmfsd_pkg;

    localparam int CAPTURE_DEPTH_DEF = 16;
    localparam int MAX_CHANNELS_DEF  = 8;

    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_CAPTURE = 2'd0,
        MODE_TIMEOUT = 2'd1,
        MODE_READ    = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_CHANNEL  = 2'd0,
        STAT_TIMEOUT  = 2'd1,
        STAT_NO_SYNC  = 2'd2,
        STAT_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_MIN   = 3'd0,
        CFG_CHAN_MAX   = 3'd1,
        CFG_CONF_MIN   = 3'd2,
        CFG_ZERO_DUTY  = 3'd3,
        CFG_DUTY_GAIN  = 3'd4,
        CFG_CHAN_COUNT = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SUPD,
        ST_EMIT,
        ST_CH_RD,
        ST_CH_DAT,
        ST_CH_MUL,
        ST_CH_OUT
    } t_state;

    localparam logic [15:0] RST_SYNC_MIN   = 16'd4000;
    localparam logic [15:0] RST_CHAN_MAX   = 16'd2500;
    localparam logic [7:0]  RST_CONF_MIN   = 8'd3;
    localparam logic [15:0] RST_ZERO_DUTY  = 16'd1060;
    localparam logic [23:0] RST_DUTY_GAIN  = 24'd5237761;
    localparam logic [3:0]  RST_CHAN_COUNT = 4'd8;

    localparam logic [16:0] DUTY_FULL = 17'd65536;

endpackage

// ----- rtl/ppm_frame_sync_and_channel_decode_unit.sv -----
// PPM frame sync and channel decoder, top level
//
// Input channel (i_in_valid / o_in_ready) takes one item per transfer:
// a capture writes the timer value into the capture memory, a timeout
// event sets the lost-signal flag, a read decodes the stored frame.
// Captures and timeout events give no result.
// A read while timed out, or without sync, gives one result. Without
// sync the read walks the memory from slot 0 up to the sync gap or
// the last slot.
// A synced read gives one result per channel, ending after a too-long
// pulse; after a seed read at the sync slot, each channel is read on the
// single memory read port, multiplied in the registered duty multiplier.
// Results sit in an output register (o_out_valid / i_out_ready); the
// decoder stops before loading a new result while the last one is
// untaken, and a capture may be taken while a result still waits.
// Reset clears the control state and the memory valid bits; the capture
// memory reads as zero until each entry has been written. No clearing pass is needed.
// Configuration writes (i_cfg_we) take effect at once; the user must write idle only, the block does not enforce it.
module ppm_frame_sync_and_channel_decode_unit
    import ppmfsd_pkg::*;
#(
    parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
    parameter int MAX_CHANNELS  = MAX_CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [15:0]          i_capture_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [2:0]           o_channel_index,
    output logic [15:0]          o_pulse_ticks,
    output logic [16:0]          o_duty,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(CAPTURE_DEPTH);
    localparam int NW = $clog2(MAX_CHANNELS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPTURE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(CAPTURE_DEPTH);

    function automatic logic [NW-1:0] clamp_n(input logic [3:0] cc);
        logic [NW-1:0] res;
        if (cc == 4'd0) begin
            res = NW'(1);
        end else if ({1'b0, cc} > 5'(MAX_CHANNELS)) begin
            res = NW'(MAX_CHANNELS);
        end else begin
            res = NW'(cc);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    // configuration
    logic [15:0] r_sync_min, r_chan_max, r_zero_duty;
    logic [7:0]  r_conf_min;
    logic [23:0] r_gain;
    logic [3:0]  r_chan_cnt;

    // block state
    t_state        r_state, n_state;
    logic [AW-1:0] r_wslot;
    logic          r_timeout;
    logic          r_sync_valid;
    logic [AW-1:0] r_sync_slot;
    logic          r_cand_valid;
    logic [AW-1:0] r_cand_slot;
    logic [7:0]    r_conf;
    logic [CAPTURE_DEPTH-1:0] r_mvalid;

    // capture memory
    logic [15:0]   mem [CAPTURE_DEPTH];
    logic [15:0]   r_rdata;
    logic          r_rvalid;
    logic [15:0]   rdata;

    // walk datapath
    logic [AW-1:0] r_raddr;
    logic [AW:0]   r_scnt;
    logic          r_dval;
    logic [AW-1:0] r_didx;
    logic [15:0]   r_prev;
    logic          r_found;
    logic [AW-1:0] r_fslot;
    logic          r_seed;
    logic [NW-1:0] r_ch;
    logic [NW-1:0] r_n;
    logic [15:0]   r_w;
    logic          r_err;
    logic [39:0]   r_prod;
    logic          r_pos;
    t_status       r_emit_status;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_o_status;
    logic [2:0]    r_o_index;
    logic [15:0]   r_o_ticks;
    logic [16:0]   r_o_duty;
    logic          r_o_last;

    logic          in_fire, out_free, out_load, rd_en, wr_en;
    logic [15:0]   slot_w;
    logic          last_ch, same_cand;
    logic [7:0]    n_conf;
    logic [16:0]   duty_c;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign wr_en    = in_fire && (i_mode == MODE_CAPTURE);
    assign rdata    = r_rvalid ? r_rdata : 16'd0;
    assign slot_w   = (r_didx == '0) ? rdata : rdata - r_prev;
    assign last_ch  = (NW'(r_ch + NW'(1)) == r_n);

    assign same_cand = r_found && r_cand_valid && (r_fslot == r_cand_slot);
    assign n_conf    = !same_cand ? 8'd0 : (r_conf == 8'hFF) ? r_conf : r_conf + 8'd1;
    assign duty_c    = !r_pos ? 17'd0 :
                       (r_prod[39:16] > 24'(DUTY_FULL)) ? DUTY_FULL : r_prod[32:16];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_mode == MODE_READ) begin
                    if (r_timeout) begin
                        n_state = ST_EMIT;
                    end else if (!r_sync_valid) begin
                        n_state = ST_SRCH;
                    end else begin
                        n_state = ST_CH_RD;
                    end
                end
            end
            ST_SRCH: begin
                if (r_dval && (slot_w > r_sync_min || r_didx == LAST_SLOT)) begin
                    n_state = ST_SUPD;
                end
            end
            ST_SUPD:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CH_RD:  n_state = ST_CH_DAT;
            ST_CH_DAT: n_state = r_seed ? ST_CH_RD : ST_CH_MUL;
            ST_CH_MUL: n_state = ST_CH_OUT;
            ST_CH_OUT: begin
                if (out_free) begin
                    n_state = (r_err || last_ch) ? ST_IDLE : ST_CH_DAT;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_SRCH:   rd_en = (r_scnt != DEPTH_CNT);
            ST_CH_RD:  rd_en = 1'b1;
            ST_CH_MUL: rd_en = !r_err && !last_ch;
            ST_EMIT,
            ST_CH_OUT: out_load = out_free;
            default: ;
        endcase
    end

    // capture memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wslot] <= i_capture_value;
        end
        if (rd_en) begin
            r_rdata <= mem[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_mvalid[r_wslot] <= 1'b1;
            end
            if (rd_en) begin
                r_rvalid <= r_mvalid[r_raddr];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_sync_min   <= RST_SYNC_MIN;
            r_chan_max   <= RST_CHAN_MAX;
            r_conf_min   <= RST_CONF_MIN;
            r_zero_duty  <= RST_ZERO_DUTY;
            r_gain       <= RST_DUTY_GAIN;
            r_chan_cnt   <= RST_CHAN_COUNT;
            r_wslot      <= '0;
            r_timeout    <= 1'b0;
            r_sync_valid <= 1'b0;
            r_sync_slot  <= '0;
            r_cand_valid <= 1'b0;
            r_cand_slot  <= '0;
            r_conf       <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SYNC_MIN:   r_sync_min  <= i_cfg_data[15:0];
                    CFG_CHAN_MAX:   r_chan_max  <= i_cfg_data[15:0];
                    CFG_CONF_MIN:   r_conf_min  <= i_cfg_data[7:0];
                    CFG_ZERO_DUTY:  r_zero_duty <= i_cfg_data[15:0];
                    CFG_DUTY_GAIN:  r_gain      <= i_cfg_data[23:0];
                    CFG_CHAN_COUNT: r_chan_cnt  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (wr_en) begin
                r_wslot <= inc_slot(r_wslot);
                if (r_wslot == LAST_SLOT) begin
                    r_timeout <= 1'b0;
                end
            end
            if (in_fire && i_mode == MODE_TIMEOUT) begin
                r_timeout <= 1'b1;
            end
            if (in_fire && i_mode == MODE_READ && r_timeout) begin
                r_sync_valid <= 1'b0;
            end
            if (r_state == ST_SUPD) begin
                r_conf       <= n_conf;
                r_cand_valid <= r_found;
                r_cand_slot  <= r_found ? r_fslot : '0;
                if (r_found && n_conf >= r_conf_min) begin
                    r_sync_valid <= 1'b1;
                    r_sync_slot  <= r_fslot;
                end
            end
            if (r_state == ST_CH_OUT && out_load && r_err) begin
                r_sync_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk datapath and result payload
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_raddr <= inc_slot(r_raddr);
            r_didx  <= r_raddr;
        end
        case (r_state)
            ST_IDLE: begin
                r_raddr       <= r_sync_valid ? r_sync_slot : '0;
                r_scnt        <= '0;
                r_dval        <= 1'b0;
                r_seed        <= 1'b1;
                r_ch          <= '0;
                r_n           <= clamp_n(r_chan_cnt);
                r_emit_status <= r_timeout ? STAT_TIMEOUT : STAT_NO_SYNC;
            end
            ST_SRCH: begin
                r_dval <= rd_en;
                if (rd_en) begin
                    r_scnt <= r_scnt + (AW + 1)'(1);
                end
                if (r_dval) begin
                    r_prev  <= rdata;
                    r_found <= slot_w > r_sync_min;
                    r_fslot <= r_didx;
                end
            end
            ST_CH_DAT: begin
                r_prev <= rdata;
                r_seed <= 1'b0;
                r_w    <= slot_w;
                r_err  <= slot_w > r_chan_max;
            end
            ST_CH_MUL: begin
                r_prod <= (r_w - r_zero_duty) * r_gain;
                r_pos  <= r_w > r_zero_duty;
            end
            ST_CH_OUT: begin
                if (out_load) begin
                    r_ch <= NW'(r_ch + NW'(1));
                end
            end
            default: ;
        endcase
        if (out_load) begin
            if (r_state == ST_EMIT) begin
                r_o_status <= r_emit_status;
                r_o_index  <= 3'd0;
                r_o_ticks  <= 16'd0;
                r_o_duty   <= 17'd0;
                r_o_last   <= 1'b1;
            end else begin
                r_o_status <= r_err ? STAT_TOO_LONG : STAT_CHANNEL;
                r_o_index  <= 3'(r_ch);
                r_o_ticks  <= r_w;
                r_o_duty   <= r_err ? 17'd0 : duty_c;
                r_o_last   <= r_err || last_ch;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_channel_index = r_o_index;
    assign o_pulse_ticks   = r_o_ticks;
    assign o_duty          = r_o_duty;
    assign o_last          = r_o_last;

endmodule

// ----- rtl/ppmfsd_checker.sv -----
// Port-level checks for the PPM decoder, bound to the top level
`include "assert_macros.svh"

module ppmfsd_checker
    import ppmfsd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [1:0]           i_mode,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           o_status,
    input logic [2:0]           o_channel_index,
    input logic [15:0]          o_pulse_ticks,
    input logic [16:0]          o_duty
    ,
    input logic                 o_last
);

    `PPM_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    `PPM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped under stall")

    `PPM_ASSERT(a_read_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_mode == MODE_READ |=> !o_in_ready, "read transfer left input ready")

    `PPM_ASSERT(a_flag_result, i_clk, i_rst_n, o_out_valid && (o_status == STAT_TIMEOUT || o_status == STAT_NO_SYNC) |-> o_last && o_channel_index == 3'd0 && o_pulse_ticks == 16'd0 && o_duty == 17'd0, "malformed status result")

    `PPM_ASSERT(a_duty_range, i_clk, i_rst_n, o_out_valid |-> o_duty <= DUTY_FULL && (o_status != STAT_TOO_LONG || (o_last && o_duty == 17'd0)), "duty out of range")

endmodule

bind ppm_frame_sync_and_channel_decode_unit ppmfsd_checker u_ppmfsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_mode          (i_mode),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_channel_index (o_channel_index),
    .o_pulse_ticks   (o_pulse_ticks),
    .o_duty          (o_duty),
    .o_last          (o_last)
);
